// ===== src/bsa_pkg.sv =====
// shared constants, payload structs and controller/datapath handshake types
package bsa_pkg;

    localparam int PAGE_BYTES = 4096;
    localparam int MAX_SLOTS  = 256;

    localparam int SIZE_W     = 13;
    localparam int ADDR_W     = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_SIZE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = CFG_IDX_W'(1);

    localparam logic [SIZE_W-1:0] RESET_OBJECT_SIZE  = SIZE_W'(16);
    localparam logic [ADDR_W-1:0] RESET_BASE_ADDRESS = '0;

    // bitmap is kept as words, one word examined per scan cycle
    localparam int WORD_W = (MAX_SLOTS >= 32) ? 32 : 8;
    localparam int NWORDS = (MAX_SLOTS + WORD_W - 1) / WORD_W;
    localparam int WPTR_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int BIT_W  = $clog2(WORD_W);
    localparam int IDX_W  = WPTR_W + BIT_W;
    localparam int CNT_W  = IDX_W + 1;
    localparam int LIM_W  = $clog2(PAGE_BYTES + 1);
    localparam int DIV_W  = LIM_W;
    localparam int REM_W  = SIZE_W + 1;
    localparam int PROD_W = SIZE_W + CNT_W;
    localparam int DCNT_W = $clog2(DIV_W + 1);

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] address;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] slot_address;
        logic [1:0]        status;
    } out_item_t;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_ALLOC_OK,
        RES_FREE_OK,
        RES_FULL,
        RES_RANGE
    } res_op_t;

    typedef struct packed {
        logic    in_load;
        logic    div_start;
        logic    div_for_count;
        logic    cnt_load;
        logic    lim_load;
        logic    scan_step;
        logic    prod_load;
        logic    rng_load;
        logic    bit_clr;
        logic    out_load;
        res_op_t res_op;
    } ctrl_cmd_t;

    typedef struct packed {
        logic new_mode;
        logic size_wr;
        logic div_done;
        logic scan_found;
        logic scan_last;
        logic in_range;
        logic out_free;
    } dp_sts_t;

endpackage

// ===== src/bitmap_slot_allocator_unit.sv =====
// top level of the bitmap slot allocator: controller plus datapath
// One item is in work at a time. An allocate scans the used bitmap one 32-slot
// word per cycle (up to 8 words for 256 slots), then multiplies the slot index
// by the object size and adds the base; a free is range checked first and, if
// in range, runs the 13-step shared divider for offset / size. The controller
// goes back to idle, freeing the input side, in the cycle after a result is
// loaded into the output register. After reset and after an object_size write
// made while idle or during the count setup, the block computes the slot count
// with the same divider and holds s_ready low until it is done.
module bitmap_slot_allocator_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [bsa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bsa_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  bsa_pkg::in_item_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output bsa_pkg::out_item_t            m_data
);
    import bsa_pkg::*;

    ctrl_cmd_t cmd;
    dp_sts_t   sts;

    bsa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bsa_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ===== src/bsa_divider.sv =====
// iterative restoring divider, one quotient bit per cycle
module bsa_divider (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [bsa_pkg::DIV_W-1:0] dividend,
    input  logic [bsa_pkg::SIZE_W-1:0] divisor,
    output logic                      done,
    output logic [bsa_pkg::DIV_W-1:0] quotient
);
    import bsa_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  quo_reg;

    logic [REM_W-1:0]  shift;
    logic [REM_W-1:0]  diff;
    logic              ge;

    always_comb begin
        shift = {rem_reg[REM_W-2:0], quo_reg[DIV_W-1]};
        ge    = shift >= {1'b0, divisor};
        diff  = shift - {1'b0, divisor};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DCNT_W'(DIV_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - DCNT_W'(1);
                if (cnt_reg == DCNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff : shift;
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== src/bsa_datapath.sv =====
// registers, used bitmap, word scan, multiplier, range check and output register
module bsa_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [bsa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bsa_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  bsa_pkg::in_item_t             s_data,
    input  logic                          m_ready,
    output logic                          m_valid,
    output bsa_pkg::out_item_t            m_data,
    input  bsa_pkg::ctrl_cmd_t            cmd,
    output bsa_pkg::dp_sts_t              sts
);
    import bsa_pkg::*;

    logic [SIZE_W-1:0] size_reg;
    logic [ADDR_W-1:0] base_reg;
    in_item_t          in_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [LIM_W-1:0]  limit_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [WPTR_W-1:0] wptr_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [DIV_W-1:0]  off_reg;
    logic              in_range_reg;
    logic [ADDR_W-1:0] res_addr_reg;
    logic [1:0]        res_status_reg;
    logic              out_valid_reg;
    out_item_t         out_data_reg;
    logic [WORD_W-1:0] map_reg [NWORDS];

    logic [DIV_W-1:0]  dividend;
    logic              div_done;
    logic [DIV_W-1:0]  quotient;
    logic [CNT_W-1:0]  cnt_next;
    logic [CNT_W-1:0]  mul_b;
    logic [PROD_W-1:0] mul_res;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] free_bits;
    logic              found;
    logic [BIT_W-1:0]  fbit;
    logic              scan_last;
    logic [ADDR_W-1:0] offset;
    logic [IDX_W-1:0]  clr_idx;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= RESET_OBJECT_SIZE;
            base_reg <= RESET_BASE_ADDRESS;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_OBJECT_SIZE:  size_reg <= cfg_wdata[SIZE_W-1:0];
                CFG_BASE_ADDRESS: base_reg <= cfg_wdata[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    assign dividend = cmd.div_for_count ? DIV_W'(PAGE_BYTES) : off_reg;

    bsa_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (size_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // slot count: zero size gives no slots, large counts are capped
    always_comb begin
        if (size_reg == '0) begin
            cnt_next = '0;
        end else if (32'(quotient) > 32'(MAX_SLOTS)) begin
            cnt_next = CNT_W'(MAX_SLOTS);
        end else begin
            cnt_next = CNT_W'(quotient);
        end
    end

    assign mul_b   = cmd.lim_load ? cnt_reg : CNT_W'(idx_reg);
    assign mul_res = PROD_W'(size_reg) * PROD_W'(mul_b);

    // current bitmap word, masked to slots below the count
    always_comb begin
        word = map_reg[wptr_reg];
        for (int j = 0; j < WORD_W; j++) begin
            mask[j] = CNT_W'({wptr_reg, BIT_W'(j)}) < cnt_reg;
        end
        free_bits = ~word & mask;
        found     = |free_bits;
        fbit      = '0;
        for (int j = WORD_W - 1; j >= 0; j--) begin
            if (free_bits[j]) begin
                fbit = BIT_W'(j);
            end
        end
    end

    assign scan_last = wptr_reg == WPTR_W'(NWORDS - 1);
    assign offset    = in_reg.address - base_reg;
    assign clr_idx   = IDX_W'(quotient);

    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            in_reg <= s_data;
        end
        if (cmd.cnt_load) begin
            cnt_reg <= cnt_next;
        end
        if (cmd.lim_load) begin
            limit_reg <= LIM_W'(mul_res);
        end
        if (cmd.prod_load) begin
            prod_reg <= mul_res;
        end
        if (cmd.in_load) begin
            wptr_reg <= '0;
        end else if (cmd.scan_step && !found && !scan_last) begin
            wptr_reg <= wptr_reg + WPTR_W'(1);
        end
        if (cmd.scan_step && found) begin
            idx_reg <= {wptr_reg, fbit};
        end
        if (cmd.rng_load) begin
            off_reg      <= DIV_W'(offset);
            in_range_reg <= offset < ADDR_W'(limit_reg);
        end
        case (cmd.res_op)
            RES_ALLOC_OK: begin
                res_addr_reg   <= base_reg + ADDR_W'(prod_reg);
                res_status_reg <= ST_OK;
            end
            RES_FREE_OK: begin
                res_addr_reg   <= '0;
                res_status_reg <= ST_OK;
            end
            RES_FULL: begin
                res_addr_reg   <= '0;
                res_status_reg <= ST_FULL;
            end
            RES_RANGE: begin
                res_addr_reg   <= '0;
                res_status_reg <= ST_RANGE;
            end
            default: ;
        endcase
        if (cmd.out_load) begin
            out_data_reg.slot_address <= res_addr_reg;
            out_data_reg.status       <= res_status_reg;
        end
    end

    // used bitmap, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int w = 0; w < NWORDS; w++) begin
                map_reg[w] <= '0;
            end
        end else if (cmd.scan_step && found) begin
            map_reg[wptr_reg][fbit] <= 1'b1;
        end else if (cmd.bit_clr) begin
            map_reg[clr_idx[IDX_W-1:BIT_W]][clr_idx[BIT_W-1:0]] <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_comb begin
        sts.new_mode   = s_data.mode;
        sts.size_wr    = cfg_we && (cfg_index == CFG_OBJECT_SIZE);
        sts.div_done   = div_done;
        sts.scan_found = found;
        sts.scan_last  = scan_last;
        sts.in_range   = in_range_reg;
        sts.out_free   = !out_valid_reg || m_ready;
    end

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_valid_reg || m_ready))
        else $error("output register overwritten while an item waits");

    a_cnt_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.lim_load |-> (cnt_reg <= CNT_W'(MAX_SLOTS)))
        else $error("slot count above the slot capacity");

    a_found_in_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.scan_step && found) |-> (CNT_W'({wptr_reg, fbit}) < cnt_reg))
        else $error("allocated slot beyond the slot count");

endmodule

// ===== src/bsa_ctrl.sv =====
// controller state machine sequencing count setup, allocate and free
module bsa_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bsa_pkg::dp_sts_t     sts,
    output bsa_pkg::ctrl_cmd_t   cmd
);
    import bsa_pkg::*;

    typedef enum logic [3:0] {
        S_CNT_GO,
        S_CNT_WAIT,
        S_CNT_SET,
        S_CNT_LIM,
        S_IDLE,
        S_SCAN,
        S_MUL,
        S_ADD,
        S_FREE_CHK,
        S_FREE_RNG,
        S_FREE_WAIT,
        S_FREE_CLR,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_op = RES_NONE;
        s_ready    = 1'b0;
        case (state_reg)
            S_CNT_GO: begin
                cmd.div_start     = 1'b1;
                cmd.div_for_count = 1'b1;
                if (!sts.size_wr) begin
                    state_next = S_CNT_WAIT;
                end
            end
            S_CNT_WAIT: begin
                if (sts.size_wr) begin
                    state_next = S_CNT_GO;
                end else if (sts.div_done) begin
                    state_next = S_CNT_SET;
                end
            end
            S_CNT_SET: begin
                cmd.cnt_load = 1'b1;
                state_next   = sts.size_wr ? S_CNT_GO : S_CNT_LIM;
            end
            S_CNT_LIM: begin
                cmd.lim_load = 1'b1;
                state_next   = sts.size_wr ? S_CNT_GO : S_IDLE;
            end
            S_IDLE: begin
                if (sts.size_wr) begin
                    state_next = S_CNT_GO;
                end else begin
                    s_ready = 1'b1;
                    if (s_valid) begin
                        cmd.in_load = 1'b1;
                        state_next  = (sts.new_mode == MODE_FREE) ? S_FREE_CHK : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_found) begin
                    state_next = S_MUL;
                end else if (sts.scan_last) begin
                    cmd.res_op = RES_FULL;
                    state_next = S_DONE;
                end
            end
            S_MUL: begin
                cmd.prod_load = 1'b1;
                state_next    = S_ADD;
            end
            S_ADD: begin
                cmd.res_op = RES_ALLOC_OK;
                state_next = S_DONE;
            end
            S_FREE_CHK: begin
                cmd.rng_load = 1'b1;
                state_next   = S_FREE_RNG;
            end
            S_FREE_RNG: begin
                if (sts.in_range) begin
                    cmd.div_start = 1'b1;
                    state_next    = S_FREE_WAIT;
                end else begin
                    cmd.res_op = RES_RANGE;
                    state_next = S_DONE;
                end
            end
            S_FREE_WAIT: begin
                if (sts.div_done) begin
                    state_next = S_FREE_CLR;
                end
            end
            S_FREE_CLR: begin
                cmd.bit_clr = 1'b1;
                cmd.res_op  = RES_FREE_OK;
                state_next  = S_DONE;
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_CNT_GO;
            end
        endcase
    end

    // slot count is worked out again after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CNT_GO;
        end else begin
            state_reg <= state_next;
        end
    end

    a_div_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.div_done |-> (state_reg == S_CNT_WAIT || state_reg == S_FREE_WAIT ||
                          state_reg == S_CNT_GO))
        else $error("divider finished outside a wait state");

    a_take_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_SCAN || state_reg == S_FREE_CHK))
        else $error("accepted item not dispatched");

    a_scan_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> ($past(state_reg) == S_IDLE || $past(state_reg) == S_SCAN))
        else $error("scan entered from an unexpected state");

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the bitmap slot allocator: queued driver, monitor, predictor
module testbench;
    import bsa_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_AT_RESULT = 300;
    localparam int HOLD_CYCLES    = 250;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_PERIODIC,
        RDY_SPARSE
    } rdy_pattern_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_OBJECT_SIZE;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;

    bitmap_slot_allocator_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // allocator state as the testbench sees it
    logic [SIZE_W-1:0] obj_size  = RESET_OBJECT_SIZE;
    logic [ADDR_W-1:0] base_addr = RESET_BASE_ADDRESS;
    bit                used_map [MAX_SLOTS];

    in_item_t  request_queue [$];
    out_item_t expected_results [$];

    int fail_count   = 0;
    int results_seen = 0;
    int ok_count     = 0;
    int full_count   = 0;
    int range_count  = 0;
    int settings_run = 1;
    int idle_cycles  = 0;

    function automatic int unsigned slot_total();
        int unsigned n;
        if (obj_size == 0) return 0;
        n = PAGE_BYTES / obj_size;
        if (n > MAX_SLOTS) n = MAX_SLOTS;
        return n;
    endfunction

    // applies one request to the tracked bitmap and returns its result
    function automatic out_item_t serve_request(in_item_t req);
        out_item_t         res;
        int unsigned       count;
        logic [ADDR_W-1:0] offset;
        logic [63:0]       limit;
        int unsigned       idx;
        res.slot_address = '0;
        count = slot_total();
        if (req.mode == MODE_ALLOC) begin
            res.status = ST_FULL;
            for (int i = 0; i < count; i++) begin
                if (!used_map[i]) begin
                    used_map[i] = 1'b1;
                    res.slot_address = base_addr + obj_size * 32'(i);
                    res.status = ST_OK;
                    break;
                end
            end
        end else begin
            offset = req.address - base_addr;
            limit  = 64'(obj_size) * 64'(count);
            if (count == 0 || 64'(offset) >= limit) begin
                res.status = ST_RANGE;
            end else begin
                idx = offset / obj_size;
                if (idx < MAX_SLOTS) used_map[idx] = 1'b0;
                res.status = ST_OK;
            end
        end
        return res;
    endfunction

    // driver: bursts of items with random gaps
    int gap_left   = 0;
    int burst_left = 8;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(serve_request(s_data));
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (request_queue.size() > 0) begin
                    s_valid <= 1'b1;
                    s_data  <= request_queue.pop_front();
                    burst_left--;
                    if (burst_left <= 0) begin
                        if ($urandom_range(0, 5) == 0) begin
                            // long stretch with no idling
                            gap_left   = 0;
                            burst_left = $urandom_range(40, 80);
                        end else begin
                            gap_left   = $urandom_range(0, 9);
                            burst_left = $urandom_range(1, 16);
                        end
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: result checks and receiver stalls
    rdy_pattern_t rdy_mode   = RDY_ALWAYS;
    int           rdy_cycle  = 0;
    int           hold_left  = 0;
    bit           hold_done  = 1'b0;
    out_item_t    want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                case (m_data.status)
                    ST_OK:    ok_count++;
                    ST_FULL:  full_count++;
                    ST_RANGE: range_count++;
                    default:  ;
                endcase
                if (expected_results.size() == 0) begin
                    $error("result item with no request outstanding: slot_address %h status %0d",
                           m_data.slot_address, m_data.status);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.slot_address !== want.slot_address) begin
                        $error("slot_address: expected %h, got %h",
                               want.slot_address, m_data.slot_address);
                        fail_count++;
                    end
                    if (m_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_data.status);
                        fail_count++;
                    end
                end
            end
            rdy_cycle++;
            if (rdy_cycle % 64 == 0) rdy_mode = rdy_pattern_t'($urandom_range(0, 3));
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
                // long hold-off so the block backs up into its input
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else begin
                case (rdy_mode)
                    RDY_ALWAYS:   m_ready <= 1'b1;
                    RDY_COIN:     m_ready <= ($urandom_range(0, 1) == 1);
                    RDY_PERIODIC: m_ready <= (rdy_cycle % 5 >= 2);
                    default:      m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_req(logic mode, logic [ADDR_W-1:0] addr);
        in_item_t req;
        req.mode    = mode;
        req.address = addr;
        request_queue.push_back(req);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        if (idx == CFG_OBJECT_SIZE) obj_size = data[SIZE_W-1:0];
        else base_addr = data;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] base);
        write_reg(CFG_OBJECT_SIZE, CFG_DATA_W'(size));
        write_reg(CFG_BASE_ADDRESS, base);
        settings_run++;
    endtask

    // sampled on the falling edge so the driver's updates have settled
    task automatic wait_drained();
        do @(negedge aclk);
        while (request_queue.size() != 0 || s_valid || expected_results.size() != 0);
    endtask

    // allocates at the given percentage; frees are mostly of real slots, with boundary and noise addresses mixed in
    task automatic add_random_requests(int n, int alloc_pct);
        int unsigned       count;
        int unsigned       pick;
        logic [ADDR_W-1:0] addr;
        count = slot_total();
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < alloc_pct) begin
                push_req(MODE_ALLOC, $urandom);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 70 && count > 0) begin
                    addr = base_addr + obj_size * 32'($urandom_range(0, count - 1))
                           + 32'($urandom_range(0, obj_size - 1));
                end else if (pick < 80) begin
                    addr = base_addr + obj_size * 32'(count) + 32'($urandom_range(0, 3)) - 32'd1;
                end else if (pick < 85) begin
                    addr = base_addr - 32'($urandom_range(1, 4));
                end else begin
                    addr = $urandom;
                end
                push_req(MODE_FREE, addr);
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // reset setting: 16-byte slots at address zero
        push_req(MODE_ALLOC, '0);
        push_req(MODE_ALLOC, '1);
        push_req(MODE_ALLOC, 32'h5555_AAAA);
        push_req(MODE_FREE, 32'h0000_0010);
        push_req(MODE_ALLOC, '0);
        push_req(MODE_FREE, 32'h0000_0021);   // inside a slot
        push_req(MODE_FREE, 32'h0000_0021);   // same slot again
        push_req(MODE_ALLOC, '0);
        push_req(MODE_FREE, 32'h0000_0FF0);
        push_req(MODE_FREE, 32'h0000_0FFF);
        push_req(MODE_FREE, 32'h0000_1000);   // first byte past the page
        push_req(MODE_FREE, 32'hFFFF_FFFF);
        push_req(MODE_FREE, 32'h7FFF_FFFF);
        push_req(MODE_FREE, 32'h8000_0000);
        push_req(MODE_FREE, 32'h0000_0000);
        push_req(MODE_ALLOC, 32'hAAAA_5555);
        add_random_requests(120, 70);
        wait_drained();

        // one page-sized slot whose range ends at the top of the address space
        apply_setting(13'd4096, 32'hFFFF_F000);
        push_req(MODE_ALLOC, '0);
        push_req(MODE_ALLOC, '0);
        push_req(MODE_FREE, 32'hFFFF_FFFF);
        push_req(MODE_FREE, 32'h0000_0000);
        push_req(MODE_ALLOC, '0);
        add_random_requests(30, 50);
        wait_drained();

        // no slots at all: zero size and sizes beyond the page
        apply_setting(13'd0, $urandom);
        push_req(MODE_ALLOC, '0);
        push_req(MODE_FREE, base_addr);
        add_random_requests(10, 50);
        wait_drained();
        apply_setting(13'd8191, 32'h0000_0000);
        add_random_requests(10, 50);
        wait_drained();
        apply_setting(13'd4097, $urandom);
        add_random_requests(10, 50);
        wait_drained();

        // slot count capped, bitmap kept across the size changes
        apply_setting(13'd8, 32'h0000_1000);
        add_random_requests(150, 80);
        wait_drained();

        // slot addresses wrap past the top
        apply_setting(13'd24, 32'hFFFF_FFF0);
        add_random_requests(120, 60);
        wait_drained();

        apply_setting(13'd512, $urandom);
        add_random_requests(80, 55);
        wait_drained();

        apply_setting(13'd17, $urandom);
        add_random_requests(120, 50);
        wait_drained();

        apply_setting(13'd16, 32'h0000_0000);
        add_random_requests(150, 40);
        wait_drained();

        for (int s = 0; s < 4; s++) begin
            apply_setting(13'($urandom_range(16, 4096)), $urandom);
            add_random_requests(60, $urandom_range(30, 80));
            wait_drained();
        end

        apply_setting(13'd16, 32'hFFFF_FFFF);
        add_random_requests(60, 60);
        wait_drained();

        repeat (40) @(posedge aclk);
        $display("checked %0d result items over %0d register settings",
                 results_seen, settings_run);
        $display("outcomes: %0d ok, %0d no free slot, %0d out of range",
                 ok_count, full_count, range_count);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/bsa_pkg.sv
src/bsa_divider.sv
src/bsa_datapath.sv
src/bsa_ctrl.sv
src/bitmap_slot_allocator_unit.sv
tb/testbench.sv
